@@ rtl/cbq_pkg.sv @@
// Shared types and constants for the cascaded biquad filter core.
// Depends on nothing; every other file takes names from here by scope.
`default_nettype none

package cbq_pkg;

    // Fixed formats of the datapath
    localparam int SAMPLE_WIDTH      = 24;
    localparam int SIGNAL_WIDTH      = 32;
    localparam int COEF_WIDTH        = 32;
    localparam int DELAY_WIDTH       = 40;
    localparam int DELAY_FRAC        = 8;
    localparam int COEFS_PER_SECTION = 5;

    // Defaults for the top-level parameters
    localparam int MAX_SECTIONS_DEF   = 128;
    localparam int COEF_FRAC_BITS_DEF = 30;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_BYPASS   = 1'b0;
    localparam logic REG_SECTIONS = 1'b1;

    // Input beat function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    // Coefficient index codes, also the order of products within a section
    localparam logic [2:0] COEF_B0 = 3'd0;
    localparam logic [2:0] COEF_B1 = 3'd1;
    localparam logic [2:0] COEF_B2 = 3'd2;
    localparam logic [2:0] COEF_A1 = 3'd3;
    localparam logic [2:0] COEF_A2 = 3'd4;

    typedef struct packed {
        logic                           func;
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic        [6:0]              coef_section;
        logic        [2:0]              coef_index;
        logic signed [COEF_WIDTH-1:0]   coef_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           saturated;
    } out_beat_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic       load_x;
        logic       mul_en;
        logic       acc_en;
        logic [2:0] acc_slot;
        logic       d_rd_en;
        logic       d_wr_en;
        logic       d_wr_zero;
    } ctl_t;

endpackage

`default_nettype wire

@@ rtl/cbq_regs.sv @@
// Configuration registers (bypass, sections in use) behind the APB-style port.
// Depends on cbq_pkg.
`default_nettype none

module cbq_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cbq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cbq_pkg::PDATA_W-1:0]  pwdata,
    output logic      [cbq_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output logic                              bypass,
    output logic      [7:0]                   sections_in_use
);

    logic       bypass_reg;
    logic [7:0] sections_reg;
    logic       wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg   <= 1'b0;
            sections_reg <= 8'd0;
        end else if (wr_en) begin
            unique case (paddr[2])
                cbq_pkg::REG_BYPASS:   bypass_reg   <= pwdata[0];
                cbq_pkg::REG_SECTIONS: sections_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            cbq_pkg::REG_BYPASS:   prdata = {{(cbq_pkg::PDATA_W-1){1'b0}}, bypass_reg};
            cbq_pkg::REG_SECTIONS: prdata = {{(cbq_pkg::PDATA_W-8){1'b0}}, sections_reg};
            default:               prdata = '0;
        endcase
    end

    assign bypass          = bypass_reg;
    assign sections_in_use = sections_reg;

endmodule

`default_nettype wire

@@ rtl/cbq_coef_mem.sv @@
// Coefficient store: one write port, one registered read port.
// Depends on cbq_pkg.
`default_nettype none

module cbq_coef_mem #(
    parameter int MAX_SECTIONS = cbq_pkg::MAX_SECTIONS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [$clog2(MAX_SECTIONS*5)-1:0]     wr_addr,
    input  wire logic signed [cbq_pkg::COEF_WIDTH-1:0] wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [$clog2(MAX_SECTIONS*5)-1:0]     rd_addr,
    output logic signed [cbq_pkg::COEF_WIDTH-1:0]      rd_data
);

    localparam int DEPTH = MAX_SECTIONS * cbq_pkg::COEFS_PER_SECTION;

    logic signed [cbq_pkg::COEF_WIDTH-1:0] coef_mem [DEPTH];
    logic signed [cbq_pkg::COEF_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            coef_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= coef_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/cbq_mac.sv @@
// Shared multiply-accumulate datapath with the two delay-state memories.
// Depends on cbq_pkg; driven by cbq_seq through cbq_pkg::ctl_t.
`default_nettype none

module cbq_mac #(
    parameter int MAX_SECTIONS   = cbq_pkg::MAX_SECTIONS_DEF,
    parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                         aclk,
    input  wire cbq_pkg::ctl_t                                ctl,
    input  wire logic signed [cbq_pkg::SAMPLE_WIDTH-1:0]      sample_x,
    input  wire logic signed [cbq_pkg::COEF_WIDTH-1:0]        coef_q,
    input  wire logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] d_rd_addr,
    input  wire logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] d_wr_addr,
    output logic signed [cbq_pkg::SIGNAL_WIDTH-1:0]           y_sig
);

    localparam int SIG_W  = cbq_pkg::SIGNAL_WIDTH;
    localparam int DLY_W  = cbq_pkg::DELAY_WIDTH;
    localparam int DFRAC  = cbq_pkg::DELAY_FRAC;
    localparam int SH     = COEF_FRAC_BITS - DFRAC;
    localparam int PROD_W = cbq_pkg::COEF_WIDTH + SIG_W;
    localparam int P_W    = PROD_W - SH;
    localparam int ACC_W  = P_W + 2;
    localparam int YS_W   = ACC_W - DFRAC;

    localparam logic signed [PROD_W-1:0] P_HALF = {{(PROD_W-1){1'b0}}, 1'b1} << (SH - 1);
    localparam logic signed [ACC_W-1:0]  Y_HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (DFRAC - 1);

    localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};
    localparam logic signed [DLY_W-1:0] DLY_MAX = {1'b0, {(DLY_W-1){1'b1}}};
    localparam logic signed [DLY_W-1:0] DLY_MIN = {1'b1, {(DLY_W-1){1'b0}}};

    logic signed [DLY_W-1:0]  d1_mem [MAX_SECTIONS];
    logic signed [DLY_W-1:0]  d2_mem [MAX_SECTIONS];
    logic signed [DLY_W-1:0]  d1_q_reg;
    logic signed [DLY_W-1:0]  d2_q_reg;

    logic signed [SIG_W-1:0]  y_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  yd_reg;
    logic signed [ACC_W-1:0]  acc1_reg;
    logic signed [ACC_W-1:0]  acc2_reg;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [P_W-1:0]    prodr;
    logic signed [ACC_W-1:0]  prodr_x;
    logic signed [ACC_W-1:0]  yd_rnd;
    logic signed [YS_W-1:0]   ys;
    logic signed [SIG_W-1:0]  y_sat;
    logic signed [ACC_W-1:0]  d2_sum;
    logic signed [DLY_W-1:0]  d1_wb;
    logic signed [DLY_W-1:0]  d2_wb;

    // One 32x32 multiplier, registered
    assign prod_next = coef_q * y_reg;

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // Round the product to delay units (floor after adding half an LSB)
    assign prod_rnd = prod_reg + P_HALF;
    assign prodr    = prod_rnd[PROD_W-1:SH];
    assign prodr_x  = ACC_W'(prodr);

    // Section output: round to signal units and clip to the signal width
    assign yd_rnd = yd_reg + Y_HALF;
    assign ys     = yd_rnd[ACC_W-1:DFRAC];

    always_comb begin
        if ((&ys[YS_W-1:SIG_W-1]) || !(|ys[YS_W-1:SIG_W-1])) begin
            y_sat = ys[SIG_W-1:0];
        end else begin
            y_sat = ys[YS_W-1] ? SIG_MIN : SIG_MAX;
        end
    end

    // New delay states, clipped to the delay width
    assign d2_sum = acc2_reg - prodr_x;

    always_comb begin
        if ((&acc1_reg[ACC_W-1:DLY_W-1]) || !(|acc1_reg[ACC_W-1:DLY_W-1])) begin
            d1_wb = acc1_reg[DLY_W-1:0];
        end else begin
            d1_wb = acc1_reg[ACC_W-1] ? DLY_MIN : DLY_MAX;
        end
        if ((&d2_sum[ACC_W-1:DLY_W-1]) || !(|d2_sum[ACC_W-1:DLY_W-1])) begin
            d2_wb = d2_sum[DLY_W-1:0];
        end else begin
            d2_wb = d2_sum[ACC_W-1] ? DLY_MIN : DLY_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_x) begin
            y_reg <= SIG_W'(sample_x);
        end else if (ctl.acc_en && ctl.acc_slot == cbq_pkg::COEF_B1) begin
            y_reg <= y_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.acc_en) begin
            unique case (ctl.acc_slot)
                cbq_pkg::COEF_B0: yd_reg   <= prodr_x + ACC_W'(d1_q_reg);
                cbq_pkg::COEF_B1: acc1_reg <= prodr_x + ACC_W'(d2_q_reg);
                cbq_pkg::COEF_B2: acc2_reg <= prodr_x;
                cbq_pkg::COEF_A1: acc1_reg <= acc1_reg - prodr_x;
                cbq_pkg::COEF_A2: ;
                default: ;
            endcase
        end
    end

    // Delay memories: registered read, one write per cycle
    always_ff @(posedge aclk) begin
        if (ctl.d_rd_en) begin
            d1_q_reg <= d1_mem[d_rd_addr];
            d2_q_reg <= d2_mem[d_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.d_wr_en) begin
            d1_mem[d_wr_addr] <= ctl.d_wr_zero ? '0 : d1_wb;
            d2_mem[d_wr_addr] <= ctl.d_wr_zero ? '0 : d2_wb;
        end
    end

    assign y_sig = y_reg;

endmodule

`default_nettype wire

@@ rtl/cbq_seq.sv @@
// Sequencer: clear sweep, beat acceptance, and the product schedule per section.
// Depends on cbq_pkg; drives cbq_coef_mem and cbq_mac.
`default_nettype none

module cbq_seq #(
    parameter int MAX_SECTIONS = cbq_pkg::MAX_SECTIONS_DEF
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      s_valid,
    input  wire cbq_pkg::in_beat_t                         s_data,
    output logic                                           s_ready,
    input  wire logic                                      bypass,
    input  wire logic [7:0]                                sections_in_use,
    input  wire logic                                      out_free,
    output logic                                           out_load,
    output logic                                           coef_wr_en,
    output logic [$clog2(MAX_SECTIONS*5)-1:0]              coef_wr_addr,
    output logic                                           coef_rd_en,
    output logic [$clog2(MAX_SECTIONS*5)-1:0]              coef_rd_addr,
    output cbq_pkg::ctl_t                                  ctl,
    output logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] d_rd_addr,
    output logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] d_wr_addr
);

    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CA_W  = $clog2(MAX_SECTIONS * cbq_pkg::COEFS_PER_SECTION);
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(MAX_SECTIONS - 1);
    localparam logic [CMP_W-1:0] SEC_CNT  = CMP_W'(MAX_SECTIONS);
    localparam logic [CA_W-1:0]  SEC_STEP = CA_W'(cbq_pkg::COEFS_PER_SECTION);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg,    state_next;
    logic [SEC_W-1:0] clr_cnt_reg,  clr_cnt_next;
    logic [SEC_W-1:0] last_sec_reg, last_sec_next;
    logic             iss_act_reg,  iss_act_next;
    logic [2:0]       iss_slot_reg, iss_slot_next;
    logic [SEC_W-1:0] iss_sec_reg,  iss_sec_next;
    logic [CA_W-1:0]  iss_base_reg, iss_base_next;
    logic             mul_vld_reg;
    logic [2:0]       mul_slot_reg;
    logic [SEC_W-1:0] mul_sec_reg;
    logic             acc_vld_reg;
    logic [2:0]       acc_slot_reg;
    logic [SEC_W-1:0] acc_sec_reg;

    logic             accept;
    logic             take_sample;
    logic             sec_ok;
    logic             coef_write;
    logic [CMP_W-1:0] used_cnt;
    logic [CMP_W-1:0] eff_cnt;
    logic             pass_thru;
    logic             wb_fire;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign take_sample = accept && (s_data.func == cbq_pkg::FUNC_SAMPLE);
    assign sec_ok      = (32'(s_data.coef_section) < 32'(MAX_SECTIONS));
    assign coef_write  = accept && (s_data.func == cbq_pkg::FUNC_COEF) && sec_ok
                         && (s_data.coef_index <= cbq_pkg::COEF_A2);

    assign used_cnt  = CMP_W'(sections_in_use);
    assign eff_cnt   = (used_cnt > SEC_CNT) ? SEC_CNT : used_cnt;
    assign pass_thru = bypass || (used_cnt == '0);
    assign wb_fire   = acc_vld_reg && (acc_slot_reg == cbq_pkg::COEF_A2);

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        last_sec_next = last_sec_reg;
        iss_act_next  = iss_act_reg;
        iss_slot_next = iss_slot_reg;
        iss_sec_next  = iss_sec_reg;
        iss_base_next = iss_base_reg;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SEC_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (take_sample) begin
                    last_sec_next = SEC_W'(eff_cnt - 1'b1);
                    iss_slot_next = cbq_pkg::COEF_B0;
                    iss_sec_next  = '0;
                    iss_base_next = '0;
                    if (pass_thru) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next   = ST_RUN;
                        iss_act_next = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                // Step through b0, b1, b2, a1, a2 of each section in turn
                if (iss_act_reg) begin
                    if (iss_slot_reg == cbq_pkg::COEF_A2) begin
                        iss_slot_next = cbq_pkg::COEF_B0;
                        iss_sec_next  = iss_sec_reg + 1'b1;
                        iss_base_next = iss_base_reg + SEC_STEP;
                        if (iss_sec_reg == last_sec_reg) begin
                            iss_act_next = 1'b0;
                        end
                    end else begin
                        iss_slot_next = iss_slot_reg + 1'b1;
                    end
                end
                if (wb_fire && (acc_sec_reg == last_sec_reg)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            iss_act_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
            acc_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            iss_act_reg <= iss_act_next;
            mul_vld_reg <= iss_act_reg;
            acc_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        last_sec_reg <= last_sec_next;
        iss_slot_reg <= iss_slot_next;
        iss_sec_reg  <= iss_sec_next;
        iss_base_reg <= iss_base_next;
        mul_slot_reg <= iss_slot_reg;
        mul_sec_reg  <= iss_sec_reg;
        acc_slot_reg <= mul_slot_reg;
        acc_sec_reg  <= mul_sec_reg;
    end

    // Coefficient store ports
    assign coef_wr_en   = coef_write;
    assign coef_wr_addr = CA_W'({s_data.coef_section, 2'b00}) + CA_W'(s_data.coef_section)
                          + CA_W'(s_data.coef_index);
    assign coef_rd_en   = iss_act_reg;
    assign coef_rd_addr = iss_base_reg + CA_W'(iss_slot_reg);

    // Delay memory ports: clear sweep, clear on coefficient write, write-back
    assign d_rd_addr = mul_sec_reg;

    always_comb begin
        priority if (state_reg == ST_CLEAR) begin
            d_wr_addr = clr_cnt_reg;
        end else if (state_reg == ST_RUN) begin
            d_wr_addr = acc_sec_reg;
        end else begin
            d_wr_addr = SEC_W'(s_data.coef_section);
        end
    end

    always_comb begin
        ctl.load_x    = take_sample;
        ctl.mul_en    = mul_vld_reg;
        ctl.acc_en    = acc_vld_reg;
        ctl.acc_slot  = acc_slot_reg;
        ctl.d_rd_en   = mul_vld_reg && (mul_slot_reg == cbq_pkg::COEF_B0);
        ctl.d_wr_en   = (state_reg == ST_CLEAR) || coef_write
                        || ((state_reg == ST_RUN) && wb_fire);
        ctl.d_wr_zero = (state_reg != ST_RUN);
    end

endmodule

`default_nettype wire

@@ rtl/cascaded_biquad_iir_filter_core.sv @@
// Samples: the next sample beat is taken only once the last result is loaded;
//   the single shared multiplier computes five products per section, one per cycle.
// Bypass or zero sections: the sample goes straight to the result beat, no products.
// Coefficient write beat: taken while idle, no result.
// Reset: synchronous, active low; then a sweep over all MAX_SECTIONS sections zeroes the
//   delay states with s_ready low. Configuration writes are taken throughout.
`default_nettype none

module cascaded_biquad_iir_filter_core #(
    parameter int MAX_SECTIONS   = cbq_pkg::MAX_SECTIONS_DEF,
    parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input beats: samples and coefficient writes
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire cbq_pkg::in_beat_t            s_data,
    // result beats
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output cbq_pkg::out_beat_t                m_data,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cbq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cbq_pkg::PDATA_W-1:0]  pwdata,
    output logic      [cbq_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CA_W  = $clog2(MAX_SECTIONS * cbq_pkg::COEFS_PER_SECTION);
    localparam int SMP_W = cbq_pkg::SAMPLE_WIDTH;
    localparam int SIG_W = cbq_pkg::SIGNAL_WIDTH;

    localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    logic                                  bypass;
    logic [7:0]                            sections_in_use;
    logic                                  out_free;
    logic                                  out_load;
    logic                                  coef_wr_en;
    logic [CA_W-1:0]                       coef_wr_addr;
    logic                                  coef_rd_en;
    logic [CA_W-1:0]                       coef_rd_addr;
    logic signed [cbq_pkg::COEF_WIDTH-1:0] coef_q;
    cbq_pkg::ctl_t                         ctl;
    logic [SEC_W-1:0]                      d_rd_addr;
    logic [SEC_W-1:0]                      d_wr_addr;
    logic signed [SIG_W-1:0]               y_sig;

    logic                                  m_valid_reg;
    cbq_pkg::out_beat_t                    m_data_reg;
    cbq_pkg::out_beat_t                    m_data_next;

    cbq_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .bypass          (bypass),
        .sections_in_use (sections_in_use)
    );

    cbq_seq #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_data          (s_data),
        .s_ready         (s_ready),
        .bypass          (bypass),
        .sections_in_use (sections_in_use),
        .out_free        (out_free),
        .out_load        (out_load),
        .coef_wr_en      (coef_wr_en),
        .coef_wr_addr    (coef_wr_addr),
        .coef_rd_en      (coef_rd_en),
        .coef_rd_addr    (coef_rd_addr),
        .ctl             (ctl),
        .d_rd_addr       (d_rd_addr),
        .d_wr_addr       (d_wr_addr)
    );

    cbq_coef_mem #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_coef_mem (
        .aclk    (aclk),
        .wr_en   (coef_wr_en),
        .wr_addr (coef_wr_addr),
        .wr_data (s_data.coef_value),
        .rd_en   (coef_rd_en),
        .rd_addr (coef_rd_addr),
        .rd_data (coef_q)
    );

    cbq_mac #(
        .MAX_SECTIONS   (MAX_SECTIONS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk      (aclk),
        .ctl       (ctl),
        .sample_x  (s_data.sample_in),
        .coef_q    (coef_q),
        .d_rd_addr (d_rd_addr),
        .d_wr_addr (d_wr_addr),
        .y_sig     (y_sig)
    );

    // Final clip to the sample width. A pass-through sample sits in y_sig
    // sign-extended, so it leaves unchanged with the flag low.
    always_comb begin
        if ((&y_sig[SIG_W-1:SMP_W-1]) || !(|y_sig[SIG_W-1:SMP_W-1])) begin
            m_data_next.sample_out = y_sig[SMP_W-1:0];
            m_data_next.saturated  = 1'b0;
        end else begin
            m_data_next.sample_out = y_sig[SIG_W-1] ? SMP_MIN : SMP_MAX;
            m_data_next.saturated  = 1'b1;
        end
    end

    // Output register: hold the result beat until taken; the sequencer may
    // accept the next input beat meanwhile.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/cbq_checker.sv @@
// Port-level checks of the biquad filter core, bound to the top level.
// Depends on cbq_pkg and cascaded_biquad_iir_filter_core.
`default_nettype none

module cbq_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire cbq_pkg::in_beat_t            s_data,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire cbq_pkg::out_beat_t           m_data,
    input wire logic                         pready
);

    // A sample beat keeps the block busy in the following cycle
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.func == cbq_pkg::FUNC_SAMPLE) |=> !s_ready)
        else $error("s_ready high right after a sample beat");

    // A coefficient write beat never creates a result beat
    a_no_result_on_coef: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.func == cbq_pkg::FUNC_COEF && !m_valid)
        |=> !m_valid)
        else $error("result beat after a coefficient write");

    // A result appears only right after the block was busy
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result beat without preceding work");

    // A stalled result beat holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result beat changed");

    // The register port never inserts wait states
    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind cascaded_biquad_iir_filter_core cbq_checker u_cbq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

`default_nettype wire
